[rtl/binary_trie_longest_prefix_match_top_defines.svh]
// Assertion helpers shared by the checker files of this block.
`ifndef BINARY_TRIE_LONGEST_PREFIX_MATCH_TOP_DEFINES_SVH
`define BINARY_TRIE_LONGEST_PREFIX_MATCH_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTLPM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTLPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/btlpm_pkg.sv]
`timescale 1ns / 1ps

package btlpm_pkg;

  localparam int NODE_COUNT_DEF = 4096;
  localparam int TAG_WIDTH_DEF  = 32;

  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 6;
  localparam int TAG_IO_W = 32;
  localparam int STATUS_W = 2;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

endpackage

[rtl/btlpm_if.sv]
`timescale 1ns / 1ps

interface btlpm_in_if;
  import btlpm_pkg::*;

  logic                valid;
  logic                ready;
  op_t                 op;
  logic [ADDR_W-1:0]   address;
  logic [LEN_W-1:0]    prefix_len;
  logic [TAG_IO_W-1:0] tag_in;

  modport source (output valid, output op, output address, output prefix_len,
                  output tag_in, input ready);
  modport sink   (input valid, input op, input address, input prefix_len,
                  input tag_in, output ready);
endinterface

interface btlpm_out_if;
  import btlpm_pkg::*;

  logic                valid;
  logic                ready;
  status_t             status;
  logic [TAG_IO_W-1:0] tag_out;

  modport source (output valid, output status, output tag_out, input ready);
  modport sink   (input valid, input status, input tag_out, output ready);
endinterface

[rtl/btlpm_node_ram.sv]
`timescale 1ns / 1ps

module btlpm_node_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 57
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/binary_trie_longest_prefix_match_top.sv]
`timescale 1ns / 1ps
// Channel   Dir  Payload                               Handshake
// in_chan   in   op, address, prefix_len, tag_in       valid / ready
// out_chan  out  status, tag_out                       valid / ready
//
// One item at a time; each trie level costs one read of the registered node memory.
// A lookup walks at most 32 levels.
// An insert walks W levels and allocates A nodes (W + A <= 32),
// and it allocates none when it is refused because the pool is full.
// Reset is synchronous; the root node sits in flip-flops, so no clearing pass is needed.
// A result waits in the output register; a second finished item stalls until it is taken.

module binary_trie_longest_prefix_match_top #(
  parameter int NODE_COUNT = btlpm_pkg::NODE_COUNT_DEF,
  parameter int TAG_WIDTH  = btlpm_pkg::TAG_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  btlpm_in_if.sink     in_chan,
  btlpm_out_if.source  out_chan
);
  import btlpm_pkg::*;

  localparam int IW   = $clog2(NODE_COUNT);
  localparam int NFW  = $clog2(NODE_COUNT + 1);
  localparam int SUMW = NFW + 1;
  localparam logic [SUMW-1:0] POOL_END = SUMW'(NODE_COUNT);

  typedef struct packed {
    logic                 holds;
    logic [IW-1:0]        zero_child;
    logic [IW-1:0]        one_child;
    logic [TAG_WIDTH-1:0] tag;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_FINISH,
    S_DONE
  } state_t;

  state_t               state_r;
  op_t                  op_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [LEN_W-1:0]     len_r;
  logic [LEN_W-1:0]     depth_r;
  logic [TAG_WIDTH-1:0] tag_r;
  logic [IW-1:0]        node_r;
  node_t                entry_r;
  node_t                root_r;
  logic                 found_r;
  logic [TAG_WIDTH-1:0] best_r;
  logic [NFW-1:0]       next_free_r;
  status_t              res_status_r;
  logic [TAG_IO_W-1:0]  res_tag_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [TAG_IO_W-1:0]  out_tag_r;

  logic [NODE_W-1:0]    mem_rdata;
  node_t                ent;
  logic                 bit_now;
  logic [IW-1:0]        child;
  logic                 more;
  logic                 hit_now;
  logic [TAG_WIDTH-1:0] tag_now;
  logic [LEN_W-1:0]     need;
  logic [SUMW-1:0]      pool_sum;
  logic                 fits;
  logic [IW-1:0]        fresh;
  node_t                parent_upd;
  node_t                final_ent;
  node_t                wr_node;
  logic                 wr_any;
  logic                 mem_we;
  logic [LEN_W-1:0]     len_in;

  // Node 0 lives in registers; every other node comes from the memory, whose
  // read was issued with the address of node_r in the cycle before.
  always_comb begin
    ent      = (node_r == '0) ? root_r : node_t'(mem_rdata);
    bit_now  = addr_r[ADDR_W-1];
    child    = bit_now ? ent.one_child : ent.zero_child;
    more     = (depth_r < len_r) && (child != '0);
    hit_now  = found_r | ent.holds;
    tag_now  = ent.holds ? ent.tag : best_r;
    need     = len_r - depth_r;
    pool_sum = SUMW'(next_free_r) + SUMW'(need);
    fits     = (pool_sum <= POOL_END);
    fresh    = next_free_r[IW-1:0];

    parent_upd = entry_r;
    if (bit_now) begin
      parent_upd.one_child = fresh;
    end else begin
      parent_upd.zero_child = fresh;
    end

    final_ent       = entry_r;
    final_ent.holds = 1'b1;
    final_ent.tag   = tag_r;

    wr_node = (state_r == S_ALLOC) ? parent_upd : final_ent;
    wr_any  = (state_r == S_ALLOC) || (state_r == S_FINISH);
    mem_we  = wr_any && (node_r != '0);

    if (in_chan.op == OP_LOOKUP || in_chan.prefix_len > MAX_LEN) begin
      len_in = MAX_LEN;
    end else begin
      len_in = in_chan.prefix_len;
    end
  end

  btlpm_node_ram #(
    .DEPTH (NODE_COUNT),
    .WIDTH (NODE_W)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (node_r),
    .wr_data (wr_node),
    .rd_addr (child),
    .rd_data (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      root_r.holds      <= 1'b0;
      root_r.zero_child <= '0;
      root_r.one_child  <= '0;
      next_free_r       <= NFW'(1);
      out_valid_r       <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || out_chan.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            op_r    <= in_chan.op;
            addr_r  <= in_chan.address;
            len_r   <= len_in;
            tag_r   <= TAG_WIDTH'(in_chan.tag_in);
            node_r  <= '0;
            depth_r <= '0;
            found_r <= 1'b0;
            state_r <= S_WALK;
          end
        end

        S_WALK: begin
          found_r <= hit_now;
          best_r  <= tag_now;
          if (more) begin
            node_r  <= child;
            depth_r <= depth_r + LEN_W'(1);
            addr_r  <= addr_r << 1;
          end else begin
            entry_r <= ent;
            if (op_r == OP_LOOKUP) begin
              res_status_r <= hit_now ? ST_OK : ST_MISS;
              res_tag_r    <= hit_now ? TAG_IO_W'(tag_now) : '0;
              state_r      <= S_DONE;
            end else if (!fits) begin
              res_status_r <= ST_FULL;
              res_tag_r    <= '0;
              state_r      <= S_DONE;
            end else if (need == '0) begin
              state_r <= S_FINISH;
            end else begin
              state_r <= S_ALLOC;
            end
          end
        end

        // Link one fresh node per cycle; the fresh node's contents start
        // cleared in entry_r and are written when it becomes the parent.
        S_ALLOC: begin
          if (node_r == '0) begin
            root_r <= parent_upd;
          end
          node_r      <= fresh;
          entry_r     <= '0;
          depth_r     <= depth_r + LEN_W'(1);
          addr_r      <= addr_r << 1;
          next_free_r <= next_free_r + NFW'(1);
          if (depth_r + LEN_W'(1) == len_r) begin
            state_r <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (node_r == '0) begin
            root_r <= final_ent;
          end
          res_status_r <= ST_OK;
          res_tag_r    <= '0;
          state_r      <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_status_r <= res_status_r;
            out_tag_r    <= res_tag_r;
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_chan.ready    = (state_r == S_IDLE);
  assign out_chan.valid   = out_valid_r;
  assign out_chan.status  = out_status_r;
  assign out_chan.tag_out = out_tag_r;

endmodule

[rtl/btlpm_checker.sv]
`timescale 1ns / 1ps
`include "binary_trie_longest_prefix_match_top_defines.svh"

module btlpm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [btlpm_pkg::STATUS_W-1:0] out_status,
  input logic [btlpm_pkg::TAG_IO_W-1:0] out_tag
);
  import btlpm_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A stalled result keeps its value until it is taken.
  `BTLPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_tag), "result changed while stalled")

  // Only a lookup hit carries a tag.
  `BTLPM_ASSERT_SAME(a_tag_zero, out_valid && out_status != ST_OK, out_tag == '0, "nonzero tag on miss or full")

  // The walk begins right after an item is taken, so no second item enters.
  `BTLPM_ASSERT_NEXT(a_one_at_a_time, in_acc, !in_ready, "item accepted during a walk")

  // A new result needs a walk after its item was taken, so valid does not rise right after an accept.
  `BTLPM_ASSERT_SAME(a_no_instant_result, $rose(out_valid), !$past(in_acc), "result raised right after accept")

endmodule

bind binary_trie_longest_prefix_match_top btlpm_checker u_btlpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_status (out_chan.status),
  .out_tag    (out_chan.tag_out)
);

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import btlpm_pkg::*;

  localparam int NODES   = NODE_COUNT_DEF;
  localparam int NODE_W  = $clog2(NODE_COUNT_DEF);
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    status_t             status;
    logic [TAG_IO_W-1:0] tag;
  } lpm_result_t;

  typedef struct packed {
    op_t                 op;
    logic [ADDR_W-1:0]   address;
    logic [LEN_W-1:0]    prefix_len;
    logic [TAG_IO_W-1:0] tag;
    logic                fixed;
    status_t             status;
    logic [TAG_IO_W-1:0] tag_out;
  } stim_row_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  len;
  } route_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  btlpm_in_if  in_chan ();
  btlpm_out_if out_chan ();

  binary_trie_longest_prefix_match_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Expectation typed into a directed row travels with the item.
  logic                fixed_check;
  status_t             fixed_status;
  logic [TAG_IO_W-1:0] fixed_tag;

  // Shadow trie.
  logic [NODE_W-1:0]        trie_zero_kid [NODES];
  logic [NODE_W-1:0]        trie_one_kid  [NODES];
  logic                     trie_marked   [NODES];
  logic [TAG_WIDTH_DEF-1:0] trie_tag      [NODES];
  int unsigned              trie_next_node;
  int unsigned              trie_inserts;

  lpm_result_t expected_results [$];
  route_t      prefix_memo [$];
  int unsigned full_rejects;
  int unsigned mismatch_count;
  bit          quiet;
  bit          sender_bursty;

  stim_row_t directed_rows [25] = '{
    '{OP_LOOKUP, 32'h0000_0000, 6'd0,  32'h0000_0000, 1'b1, ST_MISS, 32'h0000_0000},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 1'b1, ST_MISS, 32'h0000_0000},
    '{OP_INSERT, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 1'b1, ST_OK,   32'h0000_0000},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 6'd0,  32'h0000_0000, 1'b1, ST_OK,   32'hFFFF_FFFF},
    '{OP_LOOKUP, 32'hFFFF_FFFE, 6'd0,  32'h0000_0000, 1'b1, ST_MISS, 32'h0000_0000},
    '{OP_INSERT, 32'h0000_0000, 6'd0,  32'h0000_0D0F, 1'b1, ST_OK,   32'h0000_0000},
    '{OP_LOOKUP, 32'h1234_5678, 6'd0,  32'h0000_0000, 1'b1, ST_OK,   32'h0000_0D0F},
    '{OP_LOOKUP, 32'hFFFF_FFFE, 6'd0,  32'h0000_0000, 1'b1, ST_OK,   32'h0000_0D0F},
    '{OP_INSERT, 32'h0A00_0000, 6'd8,  32'h0000_000A, 1'b1, ST_OK,   32'h0000_0000},
    '{OP_LOOKUP, 32'h0A0B_0C0D, 6'd0,  32'h0000_0000, 1'b1, ST_OK,   32'h0000_000A},
    '{OP_INSERT, 32'h0A0B_0CFF, 6'd24, 32'h000A_0B0C, 1'b1, ST_OK,   32'h0000_0000},
    '{OP_LOOKUP, 32'h0A0B_0C01, 6'd0,  32'h0000_0000, 1'b1, ST_OK,   32'h000A_0B0C},
    '{OP_LOOKUP, 32'h0A0B_0D01, 6'd0,  32'h0000_0000, 1'b1, ST_OK,   32'h0000_000A},
    '{OP_INSERT, 32'h0A00_0000, 6'd8,  32'h5555_AAAA, 1'b1, ST_OK,   32'h0000_0000},
    '{OP_LOOKUP, 32'h0A7F_0000, 6'd0,  32'h0000_0000, 1'b1, ST_OK,   32'h5555_AAAA},
    '{OP_INSERT, 32'hC0A8_0100, 6'd63, 32'hC0A8_0101, 1'b1, ST_OK,   32'h0000_0000},
    '{OP_LOOKUP, 32'hC0A8_0100, 6'd0,  32'h0000_0000, 1'b1, ST_OK,   32'hC0A8_0101},
    '{OP_LOOKUP, 32'hC0A8_0101, 6'd0,  32'h0000_0000, 1'b1, ST_OK,   32'h0000_0D0F},
    '{OP_INSERT, 32'h8000_0000, 6'd1,  32'h0000_0001, 1'b1, ST_OK,   32'h0000_0000},
    '{OP_LOOKUP, 32'h8000_0000, 6'd0,  32'h0000_0000, 1'b0, ST_OK,   32'h0000_0000},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 6'd0,  32'h0000_0000, 1'b0, ST_OK,   32'h0000_0000},
    '{OP_INSERT, 32'h0000_0000, 6'd32, 32'h0000_0000, 1'b1, ST_OK,   32'h0000_0000},
    '{OP_LOOKUP, 32'h0000_0000, 6'd0,  32'h0000_0000, 1'b0, ST_OK,   32'h0000_0000},
    '{OP_INSERT, 32'h7FFF_FFFF, 6'd32, 32'h8000_0001, 1'b1, ST_OK,   32'h0000_0000},
    '{OP_LOOKUP, 32'h7FFF_FFFF, 6'd0,  32'h0000_0000, 1'b0, ST_OK,   32'h0000_0000}
  };

  initial begin
    for (int n = 0; n < NODES; n++) begin
      trie_zero_kid[n] = '0;
      trie_one_kid[n]  = '0;
      trie_marked[n]   = 1'b0;
      trie_tag[n]      = '0;
    end
    trie_next_node = 1;
    trie_inserts   = 0;
    full_rejects   = 0;
    mismatch_count = 0;
    quiet          = 1'b0;
    sender_bursty  = 1'b1;
  end

  function automatic lpm_result_t trie_apply(op_t op, logic [ADDR_W-1:0] addr,
                                             logic [LEN_W-1:0] raw_len,
                                             logic [TAG_IO_W-1:0] tag);
    int unsigned       len;
    int unsigned       depth;
    int unsigned       lvl;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] kid;
    logic [NODE_W-1:0] fresh;
    logic              found;
    lpm_result_t       res;

    len = (raw_len > MAX_LEN) ? ADDR_W : raw_len;
    res.status = ST_OK;
    res.tag = '0;
    node = '0;
    if (op == OP_INSERT) begin
      depth = 0;
      while (depth < len) begin
        kid = addr[ADDR_W-1-depth] ? trie_one_kid[node] : trie_zero_kid[node];
        if (kid == '0) break;
        node = kid;
        depth++;
      end
      // The whole insert is refused when the missing part of the path does not fit.
      if (trie_next_node + (len - depth) > NODES) begin
        res.status = ST_FULL;
        full_rejects++;
      end else begin
        for (lvl = depth; lvl < len; lvl++) begin
          fresh = NODE_W'(trie_next_node);
          trie_next_node++;
          trie_zero_kid[fresh] = '0;
          trie_one_kid[fresh]  = '0;
          trie_marked[fresh]   = 1'b0;
          if (addr[ADDR_W-1-lvl]) trie_one_kid[node] = fresh;
          else trie_zero_kid[node] = fresh;
          node = fresh;
        end
        trie_marked[node] = 1'b1;
        trie_tag[node] = tag;
        trie_inserts++;
      end
    end else begin
      found = trie_marked[0];
      if (found) res.tag = trie_tag[0];
      for (lvl = 0; lvl < ADDR_W; lvl++) begin
        node = addr[ADDR_W-1-lvl] ? trie_one_kid[node] : trie_zero_kid[node];
        if (node == '0) break;
        if (trie_marked[node]) begin
          found = 1'b1;
          res.tag = trie_tag[node];
        end
      end
      if (!found) begin
        res.status = ST_MISS;
        res.tag = '0;
      end
    end
    return res;
  endfunction

  // Keeps the top bits of a prefix and randomizes the host part.
  function automatic logic [ADDR_W-1:0] keep_top(logic [ADDR_W-1:0] base, int unsigned keep);
    logic [ADDR_W-1:0] mask;
    mask = (keep == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - keep));
    return (base & mask) | (ADDR_W'($urandom) & ~mask);
  endfunction

  task automatic make_random_item(output op_t op, output logic [ADDR_W-1:0] addr,
                                  output logic [LEN_W-1:0] len,
                                  output logic [TAG_IO_W-1:0] tag);
    route_t      r;
    int unsigned pick;
    route_t      noted;

    tag  = $urandom;
    op   = $urandom_range(0, 1) ? OP_LOOKUP : OP_INSERT;
    pick = $urandom_range(0, 9);
    if (prefix_memo.size() != 0) begin
      r = prefix_memo[$urandom_range(0, prefix_memo.size() - 1)];
    end else begin
      r.address = $urandom;
      r.len = '0;
    end
    if (op == OP_LOOKUP) begin
      len = LEN_W'($urandom_range(0, 63));
      if (pick < 6) addr = keep_top(r.address, r.len);
      else if (pick < 8) addr = keep_top(r.address, $urandom_range(0, r.len));
      else addr = $urandom;
    end else begin
      if (pick < 3) begin
        // Same prefix again with a new tag.
        addr = keep_top(r.address, r.len);
        len = r.len;
      end else if (pick < 5) begin
        // A shorter prefix on a path noted before; it needs no node unless that insert was refused.
        addr = r.address;
        len = LEN_W'($urandom_range(0, r.len));
      end else if (pick < 7) begin
        addr = keep_top(r.address, $urandom_range(0, r.len));
        len = LEN_W'($urandom_range(1, 32));
      end else begin
        addr = $urandom;
        len = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(0, 63))
                                          : LEN_W'($urandom_range(1, 32));
      end
      noted.address = addr;
      noted.len = (len > MAX_LEN) ? MAX_LEN : len;
      prefix_memo.push_back(noted);
      if (prefix_memo.size() > 256) void'(prefix_memo.pop_front());
    end
  endtask

  task automatic offer_item(op_t op, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len,
                            logic [TAG_IO_W-1:0] tag, logic fixed, status_t st,
                            logic [TAG_IO_W-1:0] tag_out);
    in_chan.valid      <= 1'b1;
    in_chan.op         <= op;
    in_chan.address    <= addr;
    in_chan.prefix_len <= len;
    in_chan.tag_in     <= tag;
    fixed_check        <= fixed;
    fixed_status       <= st;
    fixed_tag          <= tag_out;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic sender_gap();
    if ($urandom_range(0, 49) == 0) sender_bursty = !sender_bursty;
    if (!quiet && sender_bursty && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Predictor and scoreboard on the accepted items of both channels.
  always @(posedge clk) begin
    lpm_result_t predicted;
    lpm_result_t want;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        predicted = trie_apply(in_chan.op, in_chan.address, in_chan.prefix_len,
                               in_chan.tag_in);
        if (fixed_check) begin
          want.status = fixed_status;
          want.tag = fixed_tag;
          expected_results.push_back(want);
        end else begin
          expected_results.push_back(predicted);
        end
      end
      if (out_chan.valid && out_chan.ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no item pending: status %0d tag_out %h",
                 out_chan.status, out_chan.tag_out);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_chan.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_chan.status);
            mismatch_count++;
          end
          if (out_chan.tag_out !== want.tag) begin
            $error("tag_out: expected %h, got %h", want.tag, out_chan.tag_out);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Receiver: random stall bursts and one long hold-off once results flow.
  initial begin
    int unsigned stall_left;
    int unsigned seen;
    bit          long_done;
    bit          bursty;
    stall_left = 0;
    seen = 0;
    long_done = 1'b0;
    bursty = 1'b1;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid && out_chan.ready) seen++;
      if ($urandom_range(0, 99) == 0) bursty = !bursty;
      if (!rst_n) begin
        out_chan.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (!long_done && seen >= 150) begin
        long_done = 1'b1;
        stall_left = 299;
        out_chan.ready <= 1'b0;
      end else if (!quiet && bursty && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    int unsigned idle_cycles;
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    op_t                 op;
    logic [ADDR_W-1:0]   addr;
    logic [LEN_W-1:0]    len;
    logic [TAG_IO_W-1:0] tag;
    int unsigned         i;

    in_chan.valid      <= 1'b0;
    in_chan.op         <= OP_INSERT;
    in_chan.address    <= '0;
    in_chan.prefix_len <= '0;
    in_chan.tag_in     <= '0;
    fixed_check        <= 1'b0;
    fixed_status       <= ST_OK;
    fixed_tag          <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      offer_item(directed_rows[k].op, directed_rows[k].address, directed_rows[k].prefix_len,
                 directed_rows[k].tag, directed_rows[k].fixed, directed_rows[k].status,
                 directed_rows[k].tag_out);
      sender_gap();
    end

    for (i = 0; i < 650; i++) begin
      make_random_item(op, addr, len, tag);
      offer_item(op, addr, len, tag, 1'b0, ST_OK, '0);
      sender_gap();
    end

    drain_results();

    // Fill the node pool with full-length routes until four inserts are refused, giving up after 400.
    i = 0;
    while (full_rejects < 4 && i < 400) begin
      offer_item(OP_INSERT, ADDR_W'($urandom), MAX_LEN, TAG_IO_W'($urandom), 1'b0, ST_OK, '0);
      sender_gap();
      i++;
    end

    for (i = 0; i < 500; i++) begin
      if (i == 350) quiet = 1'b1;
      make_random_item(op, addr, len, tag);
      offer_item(op, addr, len, tag, 1'b0, ST_OK, '0);
      sender_gap();
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
